// ----- design/rpd_pkg.sv -----
// ---------------------------------------------------------------------------
// rpd_pkg - shared constants for the rtime page decompressor
// Default page size, symbol alphabet and result packing width.
// ---------------------------------------------------------------------------
package rpd_pkg;

   localparam int PAGE_BYTES_DEF = 4096;
   localparam int SYMBOL_COUNT   = 256;
   localparam int SYM_W          = 8;
   localparam int RESULT_BYTES   = 4;
   localparam int CNT_W          = 3;
   localparam int BLEN_W         = 13;
   localparam logic [BLEN_W-1:0] BLEN_RESET = BLEN_W'(4096);

endpackage

// ----- design/rtime_page_decompressor_unit.sv -----
// ---------------------------------------------------------------------------
// rtime_page_decompressor_unit - rtime page decompressor
// Expands literal/repeat pairs into page bytes, packed four to a word.
//
// Input channel req_*: one word is a literal byte and a repeat count.
// Result channel rsp_*: up to four bytes per word with byte_count, run_last
// on the final word of a pair, block_end when the page completes and
// overrun when copy bytes were cut at the page end.
// csr_write_enable/csr_write_data set the page length (zero acts as one,
// values above PAGE_BYTES act as PAGE_BYTES); write only while idle.
// Timing: the history memory has one read and one write port, so the copy
// runs at one byte per cycle while the output register is free to take the
// next word. The last result word of a pair is loaded as the block returns
// to idle, and the next pair can be accepted in the cycle after.
// A stalled receiver holds the output register and freezes the copy once
// the next word is complete; no bytes are lost.
// Reset clears the page length to 4096, the byte counter and the position
// table valid bits; no clearing pass is needed, the block is ready at once.
// ---------------------------------------------------------------------------
module rtime_page_decompressor_unit
   import rpd_pkg::*;
#(
   parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_literal_byte,
   input  logic [7:0]        req_repeat_count,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_out_byte_0,
   output logic [7:0]        rsp_out_byte_1,
   output logic [7:0]        rsp_out_byte_2,
   output logic [7:0]        rsp_out_byte_3,
   output logic [2:0]        rsp_byte_count,
   output logic              rsp_run_last,
   output logic              rsp_block_end,
   output logic              rsp_overrun,
   input  logic              csr_write_enable,
   input  logic [BLEN_W-1:0] csr_write_data
);

   localparam int AW = (PAGE_BYTES > 1) ? $clog2(PAGE_BYTES) : 1;
   localparam int CW = $clog2(PAGE_BYTES + 1);
   localparam int LW = (CW > BLEN_W) ? CW : BLEN_W;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_LOOKUP = 2'd1;
   localparam logic [1:0] ST_COPY   = 2'd2;

   // memories
   logic [SYM_W-1:0] hist_mem [PAGE_BYTES];
   logic [CW-1:0]    tbl_mem  [SYMBOL_COUNT];
   logic [SYM_W-1:0] hist_rd_ff;
   logic [CW-1:0]    tbl_rd_ff;

   logic             hist_we, hist_re;
   logic [AW-1:0]    hist_wa, hist_ra;
   logic [SYM_W-1:0] hist_wd;
   logic             tbl_we;

   // control and datapath registers
   logic [1:0]              state_ff, state_in;
   logic [BLEN_W-1:0]       blk_len_ff;
   logic [CW-1:0]           wc_ff, wc_in;
   logic [7:0]              rep_ff, rep_in;
   logic                    lit_end_ff, lit_end_in;
   logic                    tbl_hit_ff, tbl_hit_in;
   logic [CW-1:0]           src_ff, src_in;
   logic                    fwd_ff, fwd_in;
   logic [SYM_W-1:0]        fwd_byte_ff, fwd_byte_in;
   logic [SYM_W-1:0]        pk_ff [3];
   logic [SYM_W-1:0]        pk_in [3];
   logic [1:0]              pk_cnt_ff, pk_cnt_in;
   logic [SYMBOL_COUNT-1:0] vld_ff, vld_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [SYM_W-1:0]        rsp_byte_ff [RESULT_BYTES];
   logic [SYM_W-1:0]        rsp_byte_in [RESULT_BYTES];
   logic [CNT_W-1:0]        rsp_cnt_ff, rsp_cnt_in;
   logic                    rsp_last_ff, rsp_last_in;
   logic                    rsp_end_ff, rsp_end_in;
   logic                    rsp_ovr_ff, rsp_ovr_in;

   // effective page length
   logic [LW-1:0] bl_ext;
   logic [CW-1:0] len_eff;

   assign bl_ext = LW'(blk_len_ff);

   always_comb begin
      if (blk_len_ff == '0) begin
         len_eff = CW'(1);
      end else if (bl_ext > LW'(PAGE_BYTES)) begin
         len_eff = CW'(PAGE_BYTES);
      end else begin
         len_eff = CW'(bl_ext);
      end
   end

   // main control
   logic             out_free;
   logic             clr_start, lit_end, page_full, last_copy, last, completes;
   logic [CW-1:0]    wc_base, wc_next, wc_inc, src;
   logic [SYM_W-1:0] cp_byte;
   logic             ld_out, ld_add, ld_last, ld_end, ld_ovr;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign clr_start = (wc_ff >= len_eff);
   assign wc_base   = clr_start ? '0 : wc_ff;
   assign wc_next   = wc_base + CW'(1);
   assign lit_end   = (wc_next >= len_eff);
   assign wc_inc    = wc_ff + CW'(1);
   assign page_full = (wc_inc >= len_eff);
   assign last_copy = (rep_ff == 8'd1);
   assign last      = last_copy || page_full;
   assign completes = (pk_cnt_ff == 2'd3) || last;
   assign cp_byte   = fwd_ff ? fwd_byte_ff : hist_rd_ff;
   assign src       = tbl_hit_ff ? tbl_rd_ff : '0;

   always_comb begin
      state_in    = state_ff;
      wc_in       = wc_ff;
      rep_in      = rep_ff;
      lit_end_in  = lit_end_ff;
      tbl_hit_in  = tbl_hit_ff;
      src_in      = src_ff;
      fwd_in      = fwd_ff;
      fwd_byte_in = fwd_byte_ff;
      pk_in       = pk_ff;
      pk_cnt_in   = pk_cnt_ff;
      vld_in      = vld_ff;
      hist_we     = 1'b0;
      hist_wa     = wc_ff[AW-1:0];
      hist_wd     = cp_byte;
      hist_re     = 1'b0;
      hist_ra     = src_ff[AW-1:0];
      tbl_we      = 1'b0;
      ld_out      = 1'b0;
      ld_add      = 1'b0;
      ld_last     = 1'b0;
      ld_end      = 1'b0;
      ld_ovr      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               hist_we    = 1'b1;
               hist_wa    = wc_base[AW-1:0];
               hist_wd    = req_literal_byte;
               tbl_we     = 1'b1;
               tbl_hit_in = vld_ff[req_literal_byte] && !clr_start;
               if (clr_start || lit_end) begin
                  vld_in = '0;
               end
               if (!lit_end) begin
                  vld_in[req_literal_byte] = 1'b1;
               end
               wc_in      = lit_end ? '0 : wc_next;
               rep_in     = req_repeat_count;
               lit_end_in = lit_end;
               pk_in[0]   = req_literal_byte;
               pk_cnt_in  = 2'd1;
               state_in   = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (lit_end_ff || rep_ff == 8'd0) begin
               // literal only: send the packed literal as the final word
               if (out_free) begin
                  ld_out    = 1'b1;
                  ld_last   = 1'b1;
                  ld_end    = lit_end_ff;
                  ld_ovr    = lit_end_ff && (rep_ff != 8'd0);
                  pk_cnt_in = 2'd0;
                  state_in  = ST_IDLE;
               end
            end else begin
               hist_re  = 1'b1;
               hist_ra  = src[AW-1:0];
               src_in   = src + CW'(1);
               fwd_in   = 1'b0;
               state_in = ST_COPY;
            end
         end
         ST_COPY: begin
            if (!completes || out_free) begin
               hist_we = 1'b1;
               rep_in  = rep_ff - 8'd1;
               wc_in   = page_full ? '0 : wc_inc;
               if (page_full) begin
                  vld_in = '0;
               end
               if (completes) begin
                  ld_out    = 1'b1;
                  ld_add    = 1'b1;
                  ld_last   = last;
                  ld_end    = page_full;
                  ld_ovr    = page_full && !last_copy;
                  pk_cnt_in = 2'd0;
               end else begin
                  pk_in[pk_cnt_ff] = cp_byte;
                  pk_cnt_in        = pk_cnt_ff + 2'd1;
               end
               if (last) begin
                  state_in = ST_IDLE;
               end else begin
                  // overlapping copy: the source may be the byte written now
                  hist_re     = 1'b1;
                  src_in      = src_ff + CW'(1);
                  fwd_in      = (src_ff[AW-1:0] == wc_ff[AW-1:0]);
                  fwd_byte_in = cp_byte;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output word assembly
   always_comb begin
      for (int k = 0; k < RESULT_BYTES - 1; k++) begin
         if (k < int'(pk_cnt_ff)) begin
            rsp_byte_in[k] = pk_ff[k];
         end else if (ld_add && k == int'(pk_cnt_ff)) begin
            rsp_byte_in[k] = cp_byte;
         end else begin
            rsp_byte_in[k] = '0;
         end
      end
      // the last slot only ever takes the closing copy byte
      rsp_byte_in[RESULT_BYTES-1] = (ld_add && pk_cnt_ff == 2'd3) ? cp_byte : '0;
      rsp_cnt_in   = {1'b0, pk_cnt_ff} + CNT_W'(ld_add);
      rsp_last_in  = ld_last;
      rsp_end_in   = ld_end;
      rsp_ovr_in   = ld_ovr;
      rsp_valid_in = ld_out ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   // history memory
   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[hist_wa] <= hist_wd;
      end
      if (hist_re) begin
         hist_rd_ff <= hist_mem[hist_ra];
      end
   end

   // position table, read returns the value before this cycle's write
   always_ff @(posedge clock) begin
      if (tbl_we) begin
         tbl_mem[req_literal_byte] <= wc_next;
      end
      if (tbl_we) begin
         tbl_rd_ff <= tbl_mem[req_literal_byte];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         blk_len_ff   <= BLEN_RESET;
         wc_ff        <= '0;
         vld_ff       <= '0;
         pk_cnt_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_write_enable) begin
            blk_len_ff <= csr_write_data;
         end
         wc_ff        <= wc_in;
         vld_ff       <= vld_in;
         pk_cnt_ff    <= pk_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rep_ff      <= rep_in;
      lit_end_ff  <= lit_end_in;
      tbl_hit_ff  <= tbl_hit_in;
      src_ff      <= src_in;
      fwd_ff      <= fwd_in;
      fwd_byte_ff <= fwd_byte_in;
      pk_ff       <= pk_in;
      if (ld_out) begin
         rsp_byte_ff <= rsp_byte_in;
         rsp_cnt_ff  <= rsp_cnt_in;
         rsp_last_ff <= rsp_last_in;
         rsp_end_ff  <= rsp_end_in;
         rsp_ovr_ff  <= rsp_ovr_in;
      end
   end

   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte_0 = rsp_byte_ff[0];
   assign rsp_out_byte_1 = rsp_byte_ff[1];
   assign rsp_out_byte_2 = rsp_byte_ff[2];
   assign rsp_out_byte_3 = rsp_byte_ff[3];
   assign rsp_byte_count = rsp_cnt_ff;
   assign rsp_run_last   = rsp_last_ff;
   assign rsp_block_end  = rsp_end_ff;
   assign rsp_overrun    = rsp_ovr_ff;

endmodule

// ----- design/rpd_checker.sv -----
// ---------------------------------------------------------------------------
// rpd_checker - port checks for the rtime page decompressor
// Watches the result channel for word framing and packing rules.
// ---------------------------------------------------------------------------
module rpd_checker
   import rpd_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic [7:0]        req_literal_byte,
   input logic [7:0]        req_repeat_count,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [7:0]        rsp_out_byte_0,
   input logic [7:0]        rsp_out_byte_1,
   input logic [7:0]        rsp_out_byte_2,
   input logic [7:0]        rsp_out_byte_3,
   input logic [2:0]        rsp_byte_count,
   input logic              rsp_run_last,
   input logic              rsp_block_end,
   input logic              rsp_overrun,
   input logic              csr_write_enable,
   input logic [BLEN_W-1:0] csr_write_data
);

   // a stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_byte_count)
         && $stable(rsp_out_byte_0) && $stable(rsp_run_last))
      else $error("rsp word changed while stalled");

   // only the final word of a pair may be short
   a_full_words: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_run_last |-> rsp_byte_count == CNT_W'(RESULT_BYTES))
      else $error("non-final word not full");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_byte_count != 3'd0 && rsp_byte_count <= CNT_W'(RESULT_BYTES))
      else $error("byte count out of range");

   a_flags_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_block_end || rsp_overrun) |-> rsp_run_last)
      else $error("page flags on a non-final word");

   // unused byte slots read zero
   a_zero_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_byte_count > 3'd1 || rsp_out_byte_1 == 8'd0)
         && (rsp_byte_count > 3'd2 || rsp_out_byte_2 == 8'd0)
         && (rsp_byte_count > 3'd3 || rsp_out_byte_3 == 8'd0))
      else $error("unused byte slot not zero");

endmodule

bind rtime_page_decompressor_unit rpd_checker u_rpd_checker (.*);

// ----- tb/rpd_page_checker.sv -----
// ---------------------------------------------------------------------------
// rpd_page_checker - result checker for the rtime page decompressor
// Watches the request, result and csr ports, expands every accepted pair
// into the words it must produce and compares each result word, field by
// field, with the oldest word still expected.
// ---------------------------------------------------------------------------
module rpd_page_checker
   import rpd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic [7:0]        req_literal_byte,
   input  logic [7:0]        req_repeat_count,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic [7:0]        rsp_out_byte_0,
   input  logic [7:0]        rsp_out_byte_1,
   input  logic [7:0]        rsp_out_byte_2,
   input  logic [7:0]        rsp_out_byte_3,
   input  logic [2:0]        rsp_byte_count,
   input  logic              rsp_run_last,
   input  logic              rsp_block_end,
   input  logic              rsp_overrun,
   input  logic              csr_write_enable,
   input  logic [BLEN_W-1:0] csr_write_data,
   output int                fail_count,
   output int                pending_words
);

   typedef struct packed {
      logic [RESULT_BYTES-1:0][7:0] data;
      logic [CNT_W-1:0]             count;
      logic                         last;
      logic                         block_end;
      logic                         overrun;
   } page_word_type;

   logic [7:0]        page_bytes [PAGE_BYTES_DEF];
   logic [BLEN_W-1:0] seen_at    [SYMBOL_COUNT];
   int                fill_count;
   logic [BLEN_W-1:0] page_length;
   page_word_type     expected_words [$];

   initial begin
      fail_count    = 0;
      pending_words = 0;
   end

   task automatic clear_page();
      int s;
      for (s = 0; s < SYMBOL_COUNT; s++) begin
         seen_at[s] = '0;
      end
      fill_count = 0;
   endtask

   // literal first, then the copy run from just after the last same literal
   task automatic expand_pair(input logic [7:0] lit, input logic [7:0] rep);
      logic [7:0]    run_bytes [$];
      int            limit_len;
      int            src;
      int            left;
      bit            ended;
      bit            dropped;
      page_word_type w;
      if (page_length == 0) begin
         limit_len = 1;
      end else if (page_length > PAGE_BYTES_DEF) begin
         limit_len = PAGE_BYTES_DEF;
      end else begin
         limit_len = int'(page_length);
      end
      ended   = 1'b0;
      dropped = 1'b0;
      left    = int'(rep);
      // length lowered to or below the current fill closes the page silently
      if (fill_count >= limit_len) clear_page();
      page_bytes[fill_count] = lit;
      run_bytes = {run_bytes, lit};
      fill_count++;
      src = int'(seen_at[lit]);
      seen_at[lit] = BLEN_W'(fill_count);
      if (fill_count >= limit_len) begin
         ended   = 1'b1;
         dropped = (left != 0);
      end
      while (left != 0 && !ended) begin
         page_bytes[fill_count] = page_bytes[src];
         run_bytes = {run_bytes, page_bytes[src]};
         fill_count++;
         src++;
         left--;
         if (fill_count >= limit_len) begin
            ended   = 1'b1;
            dropped = (left != 0);
         end
      end
      if (ended) clear_page();
      while (run_bytes.size() > 0) begin
         w = '0;
         while (w.count < RESULT_BYTES && run_bytes.size() > 0) begin
            w.data[w.count] = run_bytes.pop_front();
            w.count = w.count + 1'b1;
         end
         w.last      = (run_bytes.size() == 0);
         w.block_end = w.last && ended;
         w.overrun   = w.last && dropped;
         expected_words = {expected_words, w};
      end
   endtask

   task automatic check_field(input string label, input int want, input int got);
      if (want != got) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
      end
   endtask

   always @(posedge clock) begin : watch
      page_word_type want;
      if (reset) begin
         clear_page();
         page_length = BLEN_RESET;
         expected_words.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               fail_count++;
               $display("%0t: word with nothing expected, expected none, actual %h %h %h %h n=%0d",
                        $time, rsp_out_byte_0, rsp_out_byte_1, rsp_out_byte_2,
                        rsp_out_byte_3, rsp_byte_count);
            end else begin
               want = expected_words.pop_front();
               check_field("out_byte_0", want.data[0], rsp_out_byte_0);
               check_field("out_byte_1", want.data[1], rsp_out_byte_1);
               check_field("out_byte_2", want.data[2], rsp_out_byte_2);
               check_field("out_byte_3", want.data[3], rsp_out_byte_3);
               check_field("byte_count", want.count, rsp_byte_count);
               check_field("run_last", want.last, rsp_run_last);
               check_field("block_end", want.block_end, rsp_block_end);
               check_field("overrun", want.overrun, rsp_overrun);
            end
         end
         if (req_valid && req_ready) expand_pair(req_literal_byte, req_repeat_count);
         if (csr_write_enable) page_length = csr_write_data;
      end
      pending_words = expected_words.size();
   end

endmodule

// ----- tb/tb_rtime_page_decompressor_unit.sv -----
// ---------------------------------------------------------------------------
// tb_rtime_page_decompressor_unit - testbench for the page decompressor
// Drives directed and random literal/repeat pairs over several page
// lengths with random stalls on both channels; the checker predicts and
// compares every result word.
// ---------------------------------------------------------------------------
module tb_rtime_page_decompressor_unit;
   import rpd_pkg::*;

   localparam int STALL_LIMIT = 2000;

   logic              clock            = 1'b0;
   logic              reset            = 1'b1;
   logic              req_valid        = 1'b0;
   logic [7:0]        req_literal_byte = '0;
   logic [7:0]        req_repeat_count = '0;
   logic              rsp_ready;
   logic              csr_write_enable = 1'b0;
   logic [BLEN_W-1:0] csr_write_data   = '0;
   logic              req_ready;
   logic              rsp_valid;
   logic [7:0]        rsp_out_byte_0;
   logic [7:0]        rsp_out_byte_1;
   logic [7:0]        rsp_out_byte_2;
   logic [7:0]        rsp_out_byte_3;
   logic [2:0]        rsp_byte_count;
   logic              rsp_run_last;
   logic              rsp_block_end;
   logic              rsp_overrun;
   int                fail_count;
   int                pending_words;
   bit                quiet = 1'b0;

   always #5 clock = ~clock;

   rtime_page_decompressor_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_literal_byte (req_literal_byte),
      .req_repeat_count (req_repeat_count),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte_0   (rsp_out_byte_0),
      .rsp_out_byte_1   (rsp_out_byte_1),
      .rsp_out_byte_2   (rsp_out_byte_2),
      .rsp_out_byte_3   (rsp_out_byte_3),
      .rsp_byte_count   (rsp_byte_count),
      .rsp_run_last     (rsp_run_last),
      .rsp_block_end    (rsp_block_end),
      .rsp_overrun      (rsp_overrun),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   rpd_page_checker u_page_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_literal_byte (req_literal_byte),
      .req_repeat_count (req_repeat_count),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte_0   (rsp_out_byte_0),
      .rsp_out_byte_1   (rsp_out_byte_1),
      .rsp_out_byte_2   (rsp_out_byte_2),
      .rsp_out_byte_3   (rsp_out_byte_3),
      .rsp_byte_count   (rsp_byte_count),
      .rsp_run_last     (rsp_run_last),
      .rsp_block_end    (rsp_block_end),
      .rsp_overrun      (rsp_overrun),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .pending_words    (pending_words)
   );

   // called at a falling edge; returns at the falling edge after acceptance
   // with valid still high
   task automatic send_pair(input logic [7:0] lit, input logic [7:0] rep);
      req_valid        <= 1'b1;
      req_literal_byte <= lit;
      req_repeat_count <= rep;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic set_page_length(input logic [BLEN_W-1:0] len);
      req_valid <= 1'b0;
      while (pending_words != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= len;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // literals mostly from a small set so copies land on real history
   task automatic random_phase(input int count);
      int         i;
      logic [7:0] lit;
      logic [7:0] rep;
      for (i = 0; i < count; i++) begin
         if (!quiet && $urandom_range(0, 4) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clock);
         end
         if ($urandom_range(0, 9) < 6) begin
            lit = 8'($urandom_range(0, 7));
         end else begin
            lit = 8'($urandom);
         end
         case ($urandom_range(0, 7))
            0: begin
               rep = 8'h00;
            end
            1: begin
               rep = 8'hFF;
            end
            2, 3: begin
               rep = 8'($urandom_range(1, 8));
            end
            default: begin
               rep = 8'($urandom);
            end
         endcase
         send_pair(lit, rep);
      end
   endtask

   // result side: random ready bursts, always ready once quiet
   initial begin
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(negedge clock);
         end
      end
   end

   initial begin : watchdog
      int stall_cycles;
      stall_cycles = 0;
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
         end
      end
      $display("tb_rtime_page_decompressor_unit failed");
      $finish;
   end

   initial begin
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // default page length, long overlapping copies and unseen literals
      send_pair(8'h00, 8'd0);
      send_pair(8'hFF, 8'd0);
      send_pair(8'hFF, 8'd255);
      send_pair(8'h00, 8'd255);
      send_pair(8'h5A, 8'd7);
      send_pair(8'hA5, 8'd1);
      send_pair(8'h80, 8'd128);
      send_pair(8'h01, 8'd64);

      // shorter than the current fill: next pair opens a fresh page
      set_page_length(BLEN_W'(16));
      send_pair(8'h33, 8'd3);
      send_pair(8'h33, 8'd255);
      send_pair(8'h44, 8'd14);
      send_pair(8'h44, 8'd0);

      set_page_length(BLEN_W'(1));
      send_pair(8'h12, 8'd0);
      send_pair(8'h34, 8'd200);

      // zero acts as one
      set_page_length(BLEN_W'(0));
      send_pair(8'hFF, 8'd255);
      send_pair(8'h00, 8'd0);

      // above the page size acts as the page size
      set_page_length('1);
      send_pair(8'h7E, 8'd255);
      send_pair(8'h7E, 8'd255);

      set_page_length(BLEN_W'(PAGE_BYTES_DEF));
      send_pair(8'hC3, 8'd0);
      send_pair(8'h3C, 8'd255);

      set_page_length(BLEN_W'($urandom_range(2, 40)));
      random_phase(30);
      set_page_length(BLEN_W'(PAGE_BYTES_DEF));
      random_phase(60);
      set_page_length(BLEN_W'(1));
      random_phase(10);
      set_page_length(BLEN_W'($urandom_range(100, 600)));
      random_phase(50);
      set_page_length(BLEN_W'($urandom_range(2, 64)));
      quiet = 1'b1;
      random_phase(40);

      req_valid <= 1'b0;
      while (pending_words != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (fail_count == 0) begin
         $display("tb_rtime_page_decompressor_unit passed");
      end else begin
         $display("tb_rtime_page_decompressor_unit failed");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
design/rpd_pkg.sv
design/rtime_page_decompressor_unit.sv
design/rpd_checker.sv
tb/rpd_page_checker.sv
tb/tb_rtime_page_decompressor_unit.sv
